### hw/rtl/symbol_constellation_mapper_macros.svh
// Assertion macros shared by the constellation mapper modules.
`ifndef SYMBOL_CONSTELLATION_MAPPER_MACROS_SVH
`define SYMBOL_CONSTELLATION_MAPPER_MACROS_SVH

// Same-cycle implication, sampled on aclk and off during reset.
`define SCM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and off during reset.
`define SCM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/scm_pkg.sv
// Types, constants and helper functions of the symbol constellation mapper.
package scm_pkg;

    localparam int MAX_SYMBOL_BITS = 8;
    localparam int PHASE_BITS      = 12;
    localparam int SAMPLE_BITS     = 16;
    localparam int FRAC_BITS       = SAMPLE_BITS - 3;
    localparam int SYM_W           = 8;
    localparam int TABLE_DEPTH     = 1 << MAX_SYMBOL_BITS;
    localparam int ENTRY_W         = 2 * SAMPLE_BITS;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int STEP_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SCHEME     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BITS_SYM   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BITS_QUAD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_STEP   = 2'd3;

    localparam logic [2:0] SCH_PAM   = 3'd0;
    localparam logic [2:0] SCH_QAM   = 3'd1;
    localparam logic [2:0] SCH_PSK   = 3'd2;
    localparam logic [2:0] SCH_BPSK  = 3'd3;
    localparam logic [2:0] SCH_QPSK  = 3'd4;
    localparam logic [2:0] SCH_DPSK  = 3'd5;
    localparam logic [2:0] SCH_TABLE = 3'd6;

    localparam logic [2:0]        RST_SCHEME    = SCH_BPSK;
    localparam logic [3:0]        RST_BITS_SYM  = 4'd1;
    localparam logic [3:0]        RST_BITS_QUAD = 4'd1;
    localparam logic [STEP_W-1:0] RST_AMP_STEP  = 16'd32768;

    localparam logic CMD_MAP   = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam int FIFO_DEPTH = 4;

    localparam int LEVEL_W     = 10;
    localparam int PROD_W      = LEVEL_W + STEP_W + 1;
    localparam int SAT_W       = 24;
    localparam int LEVEL_SHIFT = 16 - FRAC_BITS;
    localparam logic signed [PROD_W-1:0] LEVEL_RND = PROD_W'(1) << (LEVEL_SHIFT - 1);

    localparam int CORDIC_ITERS = 30;
    localparam int CORDIC_W     = 32;
    localparam int CORDIC_FRAC  = 30;
    localparam int OUT_SHIFT    = CORDIC_FRAC - FRAC_BITS;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_INV = 32'sd652032875;
    localparam logic signed [CORDIC_W-1:0] CORDIC_RND = CORDIC_W'(1) << (OUT_SHIFT - 1);
    localparam int HALF_SQRT2_30 = 759250125;

    localparam logic [CORDIC_W-1:0] ATAN_TURNS [0:CORDIC_ITERS-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam sample_t ONE_AMP    = sample_t'(1 << FRAC_BITS);
    localparam sample_t QPSK_AMP   =
        sample_t'((HALF_SQRT2_30 + (1 << (OUT_SHIFT - 1))) >> OUT_SHIFT);

    typedef enum logic [2:0] {
        OP_WRITE  = 3'd0,
        OP_LEVEL  = 3'd1,
        OP_PHASE  = 3'd2,
        OP_DIRECT = 3'd3,
        OP_TABLE  = 3'd4
    } op_t;

    typedef struct packed {
        logic                         command;
        logic [SYM_W-1:0]             symbol;
        logic signed [SAMPLE_BITS-1:0] entry_in_phase;
        logic signed [SAMPLE_BITS-1:0] entry_quadrature;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_in_phase;
        logic signed [SAMPLE_BITS-1:0] out_quadrature;
        logic                          symbol_error;
    } out_word_t;

    typedef struct packed {
        op_t                       op;
        logic [MAX_SYMBOL_BITS-1:0] addr;
        logic signed [LEVEL_W-1:0] lv_i;
        logic signed [LEVEL_W-1:0] lv_q;
        logic [PHASE_BITS-1:0]     phase;
        sample_t                   pt_i;
        sample_t                   pt_q;
        logic                      err;
    } job_t;

    function automatic logic [SYM_W-1:0] gray_dec(input logic [SYM_W-1:0] g);
        logic [SYM_W-1:0] v;
        v = g;
        v = v ^ (v >> 1);
        v = v ^ (v >> 2);
        v = v ^ (v >> 4);
        return v;
    endfunction

    // Level 2*s - 2^bits + 1 on an axis with 2^bits levels.
    function automatic logic signed [LEVEL_W-1:0] level_of(input logic [SYM_W-1:0] s,
                                                           input logic [3:0] bits);
        logic [LEVEL_W:0] v;
        v = (LEVEL_W+1)'({s, 1'b0}) - ((LEVEL_W+1)'(1) << bits) + (LEVEL_W+1)'(1);
        return v[LEVEL_W-1:0];
    endfunction

    function automatic sample_t sat_sample(input logic signed [SAT_W-1:0] v);
        logic [SAT_W-SAMPLE_BITS:0] top;
        top = v[SAT_W-1:SAMPLE_BITS-1];
        if (top == '0 || top == '1) begin
            return v[SAMPLE_BITS-1:0];
        end else if (v[SAT_W-1]) begin
            return SAMPLE_MIN;
        end else begin
            return SAMPLE_MAX;
        end
    endfunction

endpackage

### hw/rtl/scm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module scm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/scm_fifo.sv
// Short job queue between the classifying front end and the mapping back end.
`include "symbol_constellation_mapper_macros.svh"

module scm_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  scm_pkg::job_t in_job,
    output logic          out_valid,
    input  logic          out_ready,
    output scm_pkg::job_t out_job
);

    localparam int PTR_W = $clog2(scm_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(scm_pkg::FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(scm_pkg::FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(scm_pkg::FIFO_DEPTH);

    scm_pkg::job_t    entries_reg [scm_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_FULL);
    assign out_valid = (count_reg != '0);
    assign out_job   = entries_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= in_job;
        end
    end

    `SCM_ASSERT_NXT(a_fill_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count did not grow on a lone push")
    `SCM_ASSERT_IMP(a_fill_bound, 1'b1, count_reg <= CNT_FULL, "queue count exceeds its depth")

endmodule

### hw/rtl/scm_front.sv
// Front end: configuration registers, word intake and job classification.
`include "symbol_constellation_mapper_macros.svh"

module scm_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [scm_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [scm_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  scm_pkg::in_word_t                s_data,
    output logic                             job_valid,
    input  logic                             job_ready,
    output scm_pkg::job_t                    job,
    output logic [scm_pkg::STEP_W-1:0]       amp_step
);

    localparam int PH_EXT_W = scm_pkg::PHASE_BITS + scm_pkg::SYM_W;
    localparam int SYM_EXT_W = scm_pkg::SYM_W + 1;

    logic [2:0]                      scheme_reg;
    logic [3:0]                      bits_sym_reg;
    logic [3:0]                      bits_quad_reg;
    logic [scm_pkg::STEP_W-1:0]      amp_step_reg;
    logic [scm_pkg::PHASE_BITS-1:0]  acc_reg, acc_next;

    logic [3:0]                      m_eff, mq;
    logic [scm_pkg::SYM_W-1:0]       sym_mask, quad_mask, sym_m;
    logic [scm_pkg::SYM_W-1:0]       g_all, g_hi, g_lo;
    logic [4:0]                      ph_sh;
    logic [PH_EXT_W-1:0]             ph_ext;
    logic [scm_pkg::PHASE_BITS-1:0]  step_phase;
    logic                            in_range;
    logic                            accept, map_ok, dpsk_upd;
    scm_pkg::job_t                   job_next;

    assign s_ready  = job_ready;
    assign accept   = s_valid && s_ready;
    assign amp_step = amp_step_reg;

    always_comb begin
        if (bits_sym_reg == '0) begin
            m_eff = 4'd1;
        end else if (bits_sym_reg > 4'(scm_pkg::MAX_SYMBOL_BITS)) begin
            m_eff = 4'(scm_pkg::MAX_SYMBOL_BITS);
        end else begin
            m_eff = bits_sym_reg;
        end
        mq         = (bits_quad_reg > m_eff) ? m_eff : bits_quad_reg;
        sym_mask   = scm_pkg::SYM_W'((SYM_EXT_W'(1) << m_eff) - SYM_EXT_W'(1));
        quad_mask  = scm_pkg::SYM_W'((SYM_EXT_W'(1) << mq) - SYM_EXT_W'(1));
        sym_m      = s_data.symbol & sym_mask;
        g_all      = scm_pkg::gray_dec(sym_m);
        g_hi       = scm_pkg::gray_dec(sym_m >> mq);
        g_lo       = scm_pkg::gray_dec(sym_m & quad_mask);
        ph_sh      = 5'(scm_pkg::PHASE_BITS) - {1'b0, m_eff};
        ph_ext     = PH_EXT_W'(g_all) << ph_sh;
        step_phase = ph_ext[scm_pkg::PHASE_BITS-1:0];
        acc_next   = acc_reg + step_phase;
        in_range   = ({1'b0, s_data.symbol} < (SYM_EXT_W'(1) << m_eff));
    end

    always_comb begin
        job_next = '0;
        map_ok   = 1'b1;
        if (s_data.command == scm_pkg::CMD_WRITE) begin
            job_next.op   = scm_pkg::OP_WRITE;
            job_next.addr = s_data.symbol[scm_pkg::MAX_SYMBOL_BITS-1:0];
            job_next.pt_i = s_data.entry_in_phase;
            job_next.pt_q = s_data.entry_quadrature;
        end else begin
            case (scheme_reg)
                scm_pkg::SCH_PAM: begin
                    job_next.op   = scm_pkg::OP_LEVEL;
                    job_next.lv_i = scm_pkg::level_of(g_all, m_eff);
                end
                scm_pkg::SCH_QAM: begin
                    job_next.op   = scm_pkg::OP_LEVEL;
                    job_next.lv_i = scm_pkg::level_of(g_hi, m_eff - mq);
                    job_next.lv_q = scm_pkg::level_of(g_lo, mq);
                end
                scm_pkg::SCH_PSK: begin
                    job_next.op    = scm_pkg::OP_PHASE;
                    job_next.phase = step_phase;
                end
                scm_pkg::SCH_BPSK: begin
                    job_next.op   = scm_pkg::OP_DIRECT;
                    job_next.pt_i = s_data.symbol[0] ? -scm_pkg::ONE_AMP : scm_pkg::ONE_AMP;
                end
                scm_pkg::SCH_QPSK: begin
                    job_next.op   = scm_pkg::OP_DIRECT;
                    job_next.pt_i = s_data.symbol[0] ? -scm_pkg::QPSK_AMP : scm_pkg::QPSK_AMP;
                    job_next.pt_q = s_data.symbol[1] ? -scm_pkg::QPSK_AMP : scm_pkg::QPSK_AMP;
                end
                scm_pkg::SCH_DPSK: begin
                    job_next.op    = scm_pkg::OP_PHASE;
                    job_next.phase = acc_next;
                end
                scm_pkg::SCH_TABLE: begin
                    if (in_range) begin
                        job_next.op   = scm_pkg::OP_TABLE;
                        job_next.addr = s_data.symbol[scm_pkg::MAX_SYMBOL_BITS-1:0];
                    end else begin
                        job_next.op  = scm_pkg::OP_DIRECT;
                        job_next.err = 1'b1;
                    end
                end
                default: begin
                    map_ok = 1'b0;
                end
            endcase
        end
    end

    assign job       = job_next;
    assign job_valid = s_valid && map_ok;
    assign dpsk_upd  = accept && (s_data.command == scm_pkg::CMD_MAP)
                       && (scheme_reg == scm_pkg::SCH_DPSK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scheme_reg    <= scm_pkg::RST_SCHEME;
            bits_sym_reg  <= scm_pkg::RST_BITS_SYM;
            bits_quad_reg <= scm_pkg::RST_BITS_QUAD;
            amp_step_reg  <= scm_pkg::RST_AMP_STEP;
            acc_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    scm_pkg::REG_SCHEME:    scheme_reg    <= cfg_wr_data[2:0];
                    scm_pkg::REG_BITS_SYM:  bits_sym_reg  <= cfg_wr_data[3:0];
                    scm_pkg::REG_BITS_QUAD: bits_quad_reg <= cfg_wr_data[3:0];
                    scm_pkg::REG_AMP_STEP:  amp_step_reg  <= cfg_wr_data[scm_pkg::STEP_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (dpsk_upd) begin
                acc_reg <= acc_next;
            end
        end
    end

    `SCM_ASSERT_NXT(a_acc_hold, !dpsk_upd, $stable(acc_reg), "phase accumulator moved without a differential word")

endmodule

### hw/rtl/scm_back.sv
// Back end: table access, level scaling, pipelined CORDIC and output register.
`include "symbol_constellation_mapper_macros.svh"

module scm_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [scm_pkg::STEP_W-1:0] amp_step,
    input  logic                       job_valid,
    output logic                       job_ready,
    input  scm_pkg::job_t              job,
    output logic                       m_valid,
    input  logic                       m_ready,
    output scm_pkg::out_word_t         m_data
);

    localparam int ITERS = scm_pkg::CORDIC_ITERS;
    localparam int CW    = scm_pkg::CORDIC_W;
    localparam int PB    = scm_pkg::PHASE_BITS;
    localparam int AW    = scm_pkg::MAX_SYMBOL_BITS;
    localparam int SB    = scm_pkg::SAMPLE_BITS;

    typedef struct packed {
        logic             is_phase;
        logic [1:0]       quad;
        scm_pkg::sample_t pt_i;
        scm_pkg::sample_t pt_q;
        logic             err;
    } carry_t;

    logic                 adv, pop;
    logic [scm_pkg::ENTRY_W-1:0] ram_rd;

    logic                 s0_valid_reg;
    scm_pkg::job_t        s0_job_reg;

    logic                 s1_valid_reg;
    scm_pkg::op_t         s1_op_reg;
    logic signed [scm_pkg::PROD_W-1:0] s1_prod_i_reg, s1_prod_q_reg;
    scm_pkg::sample_t     s1_pt_i_reg, s1_pt_q_reg;
    logic                 s1_err_reg;
    logic [PB-1:0]        s1_phase_reg;

    logic signed [scm_pkg::PROD_W-1:0] lvl_i_full, lvl_q_full;
    carry_t               carry_init;

    logic                 vld_reg   [0:ITERS];
    carry_t               carry_reg [0:ITERS];
    logic signed [CW-1:0] x_reg     [0:ITERS];
    logic signed [CW-1:0] y_reg     [0:ITERS];
    logic signed [CW-1:0] z_reg     [0:ITERS];

    logic signed [CW-1:0]            c_full, s_full;
    logic signed [scm_pkg::SAT_W-1:0] c_v, s_v, i_v, q_v;
    scm_pkg::out_word_t              out_next;

    logic                 m_valid_reg;
    scm_pkg::out_word_t   m_data_reg;

    assign adv       = !m_valid_reg || m_ready;
    assign job_ready = adv;
    assign pop       = job_valid && adv;

    scm_ram #(
        .WIDTH (scm_pkg::ENTRY_W),
        .DEPTH (scm_pkg::TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (pop && (job.op == scm_pkg::OP_WRITE)),
        .wr_addr (job.addr),
        .wr_data ({job.pt_i, job.pt_q}),
        .rd_en   (pop && (job.op == scm_pkg::OP_TABLE)),
        .rd_addr (job.addr),
        .rd_data (ram_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s0_valid_reg <= job_valid;
            s1_valid_reg <= s0_valid_reg && (s0_job_reg.op != scm_pkg::OP_WRITE);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s0_job_reg    <= job;
            s1_op_reg     <= s0_job_reg.op;
            s1_prod_i_reg <= s0_job_reg.lv_i * $signed({1'b0, amp_step});
            s1_prod_q_reg <= s0_job_reg.lv_q * $signed({1'b0, amp_step});
            s1_err_reg    <= s0_job_reg.err;
            s1_phase_reg  <= s0_job_reg.phase;
            if (s0_job_reg.op == scm_pkg::OP_TABLE) begin
                s1_pt_i_reg <= ram_rd[scm_pkg::ENTRY_W-1:SB];
                s1_pt_q_reg <= ram_rd[SB-1:0];
            end else begin
                s1_pt_i_reg <= s0_job_reg.pt_i;
                s1_pt_q_reg <= s0_job_reg.pt_q;
            end
        end
    end

    always_comb begin
        lvl_i_full = $signed(s1_prod_i_reg + scm_pkg::LEVEL_RND) >>> scm_pkg::LEVEL_SHIFT;
        lvl_q_full = $signed(s1_prod_q_reg + scm_pkg::LEVEL_RND) >>> scm_pkg::LEVEL_SHIFT;
        carry_init.is_phase = (s1_op_reg == scm_pkg::OP_PHASE);
        carry_init.quad     = s1_phase_reg[PB-1 -: 2];
        carry_init.err      = s1_err_reg;
        if (s1_op_reg == scm_pkg::OP_LEVEL) begin
            carry_init.pt_i = scm_pkg::sat_sample(lvl_i_full[scm_pkg::SAT_W-1:0]);
            carry_init.pt_q = scm_pkg::sat_sample(lvl_q_full[scm_pkg::SAT_W-1:0]);
        end else begin
            carry_init.pt_i = s1_pt_i_reg;
            carry_init.pt_q = s1_pt_q_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            carry_reg[0] <= carry_init;
            x_reg[0]     <= scm_pkg::CORDIC_GAIN_INV;
            y_reg[0]     <= '0;
            z_reg[0]     <= CW'(s1_phase_reg[PB-3:0]) << (CW - PB);
        end
    end

    for (genvar k = 0; k < ITERS; k++) begin : g_cordic
        logic signed [CW-1:0] atan_k;
        logic                 rot_pos;

        assign atan_k  = $signed(scm_pkg::ATAN_TURNS[k]);
        assign rot_pos = !z_reg[k][CW-1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (adv) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                carry_reg[k+1] <= carry_reg[k];
                if (rot_pos) begin
                    x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] - atan_k;
                end else begin
                    x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] + atan_k;
                end
            end
        end
    end

    always_comb begin
        c_full = $signed(x_reg[ITERS] + scm_pkg::CORDIC_RND) >>> scm_pkg::OUT_SHIFT;
        s_full = $signed(y_reg[ITERS] + scm_pkg::CORDIC_RND) >>> scm_pkg::OUT_SHIFT;
        c_v    = c_full[scm_pkg::SAT_W-1:0];
        s_v    = s_full[scm_pkg::SAT_W-1:0];
        case (carry_reg[ITERS].quad)
            2'd0: begin
                i_v = c_v;
                q_v = s_v;
            end
            2'd1: begin
                i_v = -s_v;
                q_v = c_v;
            end
            2'd2: begin
                i_v = -c_v;
                q_v = -s_v;
            end
            default: begin
                i_v = s_v;
                q_v = -c_v;
            end
        endcase
        out_next.symbol_error = carry_reg[ITERS].err;
        if (carry_reg[ITERS].is_phase) begin
            out_next.out_in_phase   = scm_pkg::sat_sample(i_v);
            out_next.out_quadrature = scm_pkg::sat_sample(q_v);
        end else begin
            out_next.out_in_phase   = carry_reg[ITERS].pt_i;
            out_next.out_quadrature = carry_reg[ITERS].pt_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vld_reg[ITERS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SCM_ASSERT_IMP(a_err_zero, m_valid_reg && m_data_reg.symbol_error, m_data_reg.out_in_phase == '0 && m_data_reg.out_quadrature == '0, "error word carries a nonzero point")
    `SCM_ASSERT_IMP(a_stall_cause, job_valid && !job_ready, m_valid_reg && !m_ready, "back end stalled without a blocked output word")

endmodule

### hw/rtl/symbol_constellation_mapper.sv
// Top level of the symbol constellation mapper.
// A word that yields a result passes the queue, the table read and multiply stages, the
// 30-stage CORDIC pipeline and the output register before it shows on m_valid.
// Throughput: one word per cycle unless m_ready stalls; a 4-entry queue decouples both ends.
// Reset: synchronous, active low; scheme BPSK, one bit per symbol, one quadrature bit,
// amplitude step 32768, phase accumulator zero; table contents are undefined until written.
module symbol_constellation_mapper (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [scm_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [scm_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  scm_pkg::in_word_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output scm_pkg::out_word_t             m_data
);

    logic                       fe_valid, fe_ready;
    scm_pkg::job_t              fe_job;
    logic                       q_valid, q_ready;
    scm_pkg::job_t              q_job;
    logic [scm_pkg::STEP_W-1:0] amp_step;

    scm_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .job_valid   (fe_valid),
        .job_ready   (fe_ready),
        .job         (fe_job),
        .amp_step    (amp_step)
    );

    scm_fifo u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_job    (fe_job),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_job   (q_job)
    );

    scm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .amp_step  (amp_step),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job       (q_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
